@@ rtl/fnvh_pkg.sv @@
`default_nettype none

package fnvh_pkg;

	localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
	localparam logic [31:0] MIX_MUL_A = 32'h7feb_352d;
	localparam logic [31:0] MIX_MUL_B = 32'h846c_a68b;
	localparam int unsigned MIX_SHIFT_A = 16;
	localparam int unsigned MIX_SHIFT_B = 15;

	// One queued item: the raw byte, whether its upper 24 bits widen to ones,
	// and the two flags of the item.
	typedef struct packed {
		logic [7:0] data;
		logic       ext;
		logic       present;
		logic       last;
	} fnvh_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fnvh_qstat_t;

endpackage

`default_nettype wire

@@ rtl/fnv1a_hash_with_finalizer_core.sv @@
`default_nettype none

// FNV-1a 32-bit hash with a three-round xorshift-multiply finalizer, fed one
// byte per input item. Items are taken at up to one per cycle: the front end
// widens each byte (sign or zero extension, chosen by the one-bit config
// register, reset to sign extension) and places it in a QUEUE_DEPTH-entry
// queue; the back end absorbs one queued byte per cycle through the hash
// register and its constant multiply, which sets the sustained rate while no
// end-marked item waits for finalizer room. An item marked last hands the
// running hash to a four-register finalizer pipeline that yields its
// hash_value, and the running hash restarts at the offset basis for the next
// message. Items with neither a byte nor a last mark are accepted and have
// no effect. Write the config only while no message is in flight.
module fnv1a_hash_with_finalizer_core import fnvh_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      hash_value
);

	fnvh_qstat_t qstat;
	fnvh_entry_t push_entry;
	fnvh_entry_t head;
	logic        push;
	logic        pop;

	fnvh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.last         (last),
		.qstat        (qstat),
		.push         (push),
		.push_entry   (push_entry)
	);

	fnvh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	fnvh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

endmodule

`default_nettype wire

@@ rtl/fnvh_front.sv @@
`default_nettype none

module fnvh_front import fnvh_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        last,
	input  wire fnvh_qstat_t qstat,
	output logic             push,
	output fnvh_entry_t      push_entry
);

	logic sign_ext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_ext_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			sign_ext_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = !qstat.full;

	// Drop items with neither a byte nor an end mark: they change nothing.
	assign push = in_valid && in_ready && (byte_present || last);

	always_comb begin
		push_entry.data    = data_byte;
		push_entry.ext     = sign_ext_q && data_byte[7];
		push_entry.present = byte_present;
		push_entry.last    = last;
	end

endmodule

`default_nettype wire

@@ rtl/fnvh_queue.sv @@
`default_nettype none

module fnvh_queue import fnvh_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire fnvh_entry_t push_entry,
	input  wire logic        pop,
	output fnvh_entry_t      head,
	output fnvh_qstat_t      qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fnvh_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ rtl/fnvh_back.sv @@
`default_nettype none

module fnvh_back import fnvh_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire fnvh_qstat_t qstat,
	input  wire fnvh_entry_t head,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      hash_value
);

	logic [31:0] hash_q;
	logic [31:0] word;
	logic [31:0] stepped;
	logic [31:0] hash_next;

	logic        v_s0, v_s1, v_s2;
	logic [31:0] x_s0, x_s1, x_s2;
	logic        out_valid_q;
	logic [31:0] out_q;

	logic out_free, s2_free, s1_free, s0_free;

	assign out_free = !out_valid_q || out_ready;
	assign s2_free  = !v_s2 || out_free;
	assign s1_free  = !v_s1 || s2_free;
	assign s0_free  = !v_s0 || s1_free;

	// Plain bytes never wait; an end-marked item needs room in the finalizer.
	assign pop = !qstat.empty && (!head.last || s0_free);

	assign word      = {{24{head.ext}}, head.data};
	assign stepped   = 32'((hash_q ^ word) * FNV_PRIME);
	assign hash_next = head.present ? stepped : hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (pop) begin
			hash_q <= head.last ? FNV_BASIS : hash_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0        <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s0_free) begin
				v_s0 <= pop && head.last;
			end
			if (s1_free) begin
				v_s1 <= v_s0;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s0_free && pop && head.last) begin
			x_s0 <= hash_next;
		end
		if (s1_free && v_s0) begin
			x_s1 <= 32'((x_s0 ^ (x_s0 >> MIX_SHIFT_A)) * MIX_MUL_A);
		end
		if (s2_free && v_s1) begin
			x_s2 <= 32'((x_s1 ^ (x_s1 >> MIX_SHIFT_B)) * MIX_MUL_B);
		end
		if (out_free && v_s2) begin
			out_q <= x_s2 ^ (x_s2 >> MIX_SHIFT_A);
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = out_q;

endmodule

`default_nettype wire

@@ rtl/fnvh_checker.sv @@
`default_nettype none

module fnvh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] hash_value
);

	// The queue only fills through an accepted item.
	a_in_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("in_ready dropped without an accepted item");

	// A result leaves only when taken.
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("out_valid dropped before the item was taken");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_value))
		else $error("stalled result changed");

endmodule

bind fnv1a_hash_with_finalizer_core fnvh_checker u_fnvh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hash_value (hash_value)
);

`default_nettype wire
